@@ src/hcbd_pkg.sv @@
// hcbd_pkg: types, codes and a helper function for the chunked body decoder
// no dependencies; used by the parser, the top level and the testbench
package hcbd_pkg;

   localparam logic [7:0] CH_LF = 8'h0A;
   localparam logic [7:0] CH_CR = 8'h0D;
   localparam int unsigned COUNT_W = 64;

   typedef enum logic [2:0] {
      PH_SIZE    = 3'd0,
      PH_EXT     = 3'd1,
      PH_DATA    = 3'd2,
      PH_CRLF    = 3'd3,
      PH_TRAILER = 3'd4,
      PH_ERROR   = 3'd5
   } phase_type;

   typedef enum logic [2:0] {
      EV_PAYLOAD = 3'd0,
      EV_HEADER  = 3'd1,
      EV_CHUNK   = 3'd2,
      EV_FINAL   = 3'd3,
      EV_ERROR   = 3'd4,
      EV_TRAILER = 3'd5
   } event_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       start_message;
   } req_payload_type;

   typedef struct packed {
      logic [2:0]         event_res;
      logic [7:0]         payload_byte;
      logic [COUNT_W-1:0] chunk_length;
   } rsp_payload_type;

   typedef struct packed {
      logic            valid;
      rsp_payload_type payload;
   } step_result_type;

   typedef struct packed {
      logic       is_hex;
      logic [3:0] value;
   } hex_digit_type;

   function automatic hex_digit_type hex_decode(input logic [7:0] c);
      hex_digit_type d;
      d.is_hex = 1'b1;
      d.value  = 4'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         d.value = c[3:0];
      end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
         d.value = 4'(c[2:0] + 3'd1) + 4'd8;
      end else begin
         d.is_hex = 1'b0;
      end
      return d;
   endfunction

endpackage

@@ src/hcbd_stream_if.sv @@
// hcbd_stream_if: valid/ready channel carrying one transaction payload
// payload type is given by the instantiating module, usually from hcbd_pkg
interface hcbd_stream_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

@@ src/hcbd_parser.sv @@
// hcbd_parser: parser state registers and the per-byte decode step
// depends on hcbd_pkg
module hcbd_parser #(
   parameter int MAX_HEX_DIGITS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     accept,
   input  hcbd_pkg::req_payload_type req,
   output hcbd_pkg::step_result_type result
);
   import hcbd_pkg::*;

   localparam int DIGIT_W = $clog2(MAX_HEX_DIGITS + 1);

   phase_type          phase_ff, phase_in, phase_cur;
   logic [COUNT_W-1:0] count_ff, count_in, count_cur;
   logic [DIGIT_W-1:0] digits_ff, digits_in, digits_cur;
   hex_digit_type      hex;
   logic [7:0]         b;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_SIZE;
         count_ff  <= '0;
         digits_ff <= '0;
      end else if (accept) begin
         phase_ff  <= phase_in;
         count_ff  <= count_in;
         digits_ff <= digits_in;
      end
   end

   always_comb begin
      b          = req.data_byte;
      hex        = hex_decode(b);
      phase_cur  = req.start_message ? PH_SIZE : phase_ff;
      count_cur  = req.start_message ? '0 : count_ff;
      digits_cur = req.start_message ? '0 : digits_ff;

      phase_in  = phase_cur;
      count_in  = count_cur;
      digits_in = digits_cur;

      result.valid                = 1'b0;
      result.payload.event_res    = EV_PAYLOAD;
      result.payload.payload_byte = 8'd0;
      result.payload.chunk_length = '0;

      case (phase_cur)
         PH_SIZE, PH_EXT: begin
            if (phase_cur == PH_SIZE && hex.is_hex) begin
               if (digits_cur >= DIGIT_W'(MAX_HEX_DIGITS)) begin
                  phase_in                 = PH_ERROR;
                  result.valid             = 1'b1;
                  result.payload.event_res = EV_ERROR;
               end else begin
                  count_in  = {count_cur[COUNT_W-5:0], hex.value};
                  digits_in = DIGIT_W'(digits_cur + 1'b1);
               end
            end else if (phase_cur == PH_SIZE && digits_cur == '0) begin
               phase_in                 = PH_ERROR;
               result.valid             = 1'b1;
               result.payload.event_res = EV_ERROR;
            end else if (b == CH_LF) begin
               result.valid = 1'b1;
               if (count_cur == '0) begin
                  phase_in                 = PH_TRAILER;
                  result.payload.event_res = EV_FINAL;
               end else begin
                  phase_in                    = PH_DATA;
                  result.payload.event_res    = EV_HEADER;
                  result.payload.chunk_length = count_cur;
               end
            end else begin
               phase_in = PH_EXT;
            end
         end
         PH_DATA: begin
            count_in = count_cur - 1'b1;
            if (count_cur == COUNT_W'(1)) begin
               phase_in = PH_CRLF;
            end
            result.valid                = 1'b1;
            result.payload.event_res    = EV_PAYLOAD;
            result.payload.payload_byte = b;
         end
         PH_CRLF: begin
            if (b == CH_LF) begin
               phase_in                 = PH_SIZE;
               count_in                 = '0;
               digits_in                = '0;
               result.valid             = 1'b1;
               result.payload.event_res = EV_CHUNK;
            end else if (b != CH_CR) begin
               phase_in                 = PH_ERROR;
               result.valid             = 1'b1;
               result.payload.event_res = EV_ERROR;
            end
         end
         PH_TRAILER: begin
            result.valid                = 1'b1;
            result.payload.event_res    = EV_TRAILER;
            result.payload.payload_byte = b;
         end
         default: begin
            phase_in = PH_ERROR;
         end
      endcase
   end

endmodule

@@ src/http_chunked_body_decoder.sv @@
// Chunked body decoder: takes one byte per transaction on req_chan and returns at most one
// event per byte on rsp_chan (payload, header done with its length, chunk complete, final
// chunk, error, trailer byte). Each byte is decoded in the cycle it is accepted and its event
// lands in a single output register, so a new byte is taken every cycle as long as the
// output register is empty or being drained; one byte per clock holds because the whole
// decode step is one combinational pass in the parser. A start flag on a byte restarts
// parsing at the size field; after an error bytes are swallowed until the next start.
// depends on hcbd_pkg, hcbd_stream_if and hcbd_parser
module http_chunked_body_decoder #(
   parameter int MAX_HEX_DIGITS = 16
) (
   input logic          clock,
   input logic          reset,
   hcbd_stream_if.sink   req_chan,
   hcbd_stream_if.source rsp_chan
);
   import hcbd_pkg::*;

   logic            accept;
   step_result_type step;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_payload_ff;

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;

   hcbd_parser #(
      .MAX_HEX_DIGITS(MAX_HEX_DIGITS)
   ) u_parser (
      .clock (clock),
      .reset (reset),
      .accept(accept),
      .req   (req_chan.payload),
      .result(step)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept && step.valid) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && step.valid) begin
         rsp_payload_ff <= step.payload;
      end
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_payload_ff;

endmodule

@@ tb/sv/http_chunked_body_decoder_tb.sv @@
`timescale 1ns / 1ps
// http_chunked_body_decoder_tb: byte stream tests for the chunked body decoder
// depends on hcbd_pkg, hcbd_stream_if and http_chunked_body_decoder
module http_chunked_body_decoder_tb;
   import hcbd_pkg::*;

   localparam int MAX_HEX_DIGITS = 16;
   localparam int STALL_LIMIT    = 2000;
   localparam int DRAIN_CYCLES   = 8;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic sink_ready = 1'b0;
   bit   full_rate = 1'b0;
   int   sent_count = 0;
   int   err_count = 0;
   int   stall_cycles = 0;

   // decoder state as predicted
   phase_type   parse_phase;
   logic [63:0] size_acc;
   logic [4:0]  digit_cnt;
   logic [63:0] bytes_left;

   rsp_payload_type expected_events[$];

   hcbd_stream_if #(.payload_type(req_payload_type)) req_chan ();
   hcbd_stream_if #(.payload_type(rsp_payload_type)) rsp_chan ();

   assign rsp_chan.ready = sink_ready;

   http_chunked_body_decoder #(
      .MAX_HEX_DIGITS(MAX_HEX_DIGITS)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan)
   );

   always #5 clock = ~clock;

   function automatic void restart_parse();
      parse_phase = PH_SIZE;
      size_acc    = '0;
      digit_cnt   = '0;
      bytes_left  = '0;
   endfunction

   function automatic bit finish_header(output rsp_payload_type ev);
      ev = '0;
      if (size_acc == 0) begin
         parse_phase  = PH_TRAILER;
         ev.event_res = EV_FINAL;
      end else begin
         bytes_left      = size_acc;
         parse_phase     = PH_DATA;
         ev.event_res    = EV_HEADER;
         ev.chunk_length = size_acc;
      end
      return 1'b1;
   endfunction

   function automatic bit decode_byte(input logic [7:0] b, input logic st,
                                      output rsp_payload_type ev);
      logic       is_hex;
      logic [3:0] nib;
      bit         got;
      ev     = '0;
      got    = 1'b0;
      is_hex = 1'b1;
      nib    = 4'd0;
      if (b >= 8'h30 && b <= 8'h39) begin
         nib = 4'(b - 8'h30);
      end else if (b >= 8'h41 && b <= 8'h46) begin
         nib = 4'(b - 8'h37);
      end else if (b >= 8'h61 && b <= 8'h66) begin
         nib = 4'(b - 8'h57);
      end else begin
         is_hex = 1'b0;
      end
      if (st) begin
         restart_parse();
      end
      case (parse_phase)
         PH_SIZE: begin
            if (is_hex) begin
               if (digit_cnt >= MAX_HEX_DIGITS) begin
                  parse_phase  = PH_ERROR;
                  ev.event_res = EV_ERROR;
                  got          = 1'b1;
               end else begin
                  size_acc  = {size_acc[59:0], nib};
                  digit_cnt = digit_cnt + 5'd1;
               end
            end else if (digit_cnt == 0) begin
               parse_phase  = PH_ERROR;
               ev.event_res = EV_ERROR;
               got          = 1'b1;
            end else begin
               parse_phase = PH_EXT;
               if (b == CH_LF) got = finish_header(ev);
            end
         end
         PH_EXT: begin
            if (b == CH_LF) got = finish_header(ev);
         end
         PH_DATA: begin
            bytes_left = bytes_left - 64'd1;
            if (bytes_left == 0) parse_phase = PH_CRLF;
            ev.event_res    = EV_PAYLOAD;
            ev.payload_byte = b;
            got             = 1'b1;
         end
         PH_CRLF: begin
            if (b == CH_LF) begin
               restart_parse();
               ev.event_res = EV_CHUNK;
               got          = 1'b1;
            end else if (b != CH_CR) begin
               parse_phase  = PH_ERROR;
               ev.event_res = EV_ERROR;
               got          = 1'b1;
            end
         end
         PH_TRAILER: begin
            ev.event_res    = EV_TRAILER;
            ev.payload_byte = b;
            got             = 1'b1;
         end
         default: begin
            parse_phase = PH_ERROR;
         end
      endcase
      return got;
   endfunction

   task automatic send_byte(input logic [7:0] b, input logic st);
      rsp_payload_type ev;
      if (!full_rate) begin
         while ($urandom_range(99) < 29) begin
            req_chan.valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_chan.valid   <= 1'b1;
      req_chan.payload <= {b, st};
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      sent_count++;
      if (decode_byte(b, st, ev)) expected_events.push_back(ev);
   endtask

   task automatic send_size(input logic [63:0] value, input int ndigits, input logic st);
      logic [3:0] nib;
      logic [7:0] c;
      for (int i = ndigits - 1; i >= 0; i--) begin
         nib = 4'(value >> (4 * i));
         if (nib < 4'd10) c = 8'h30 + 8'(nib);
         else c = ($urandom_range(1) ? 8'h41 : 8'h61) + 8'(nib) - 8'd10;
         send_byte(c, (i == ndigits - 1) ? st : 1'b0);
      end
   endtask

   task automatic send_chunk(input int unsigned len, input logic st, input bit bad_end);
      int         total;
      logic [7:0] b;
      total = (len > 15) ? 2 : 1;
      if ($urandom_range(3) == 0) total = int'($urandom_range(16, total));
      send_size(64'(len), total, st);
      // optional extension, skipped up to lf
      if ($urandom_range(3) == 0) begin
         send_byte(";", 1'b0);
         repeat ($urandom_range(4)) begin
            b = 8'($urandom);
            if (b == CH_LF) b = "x";
            send_byte(b, 1'b0);
         end
      end
      if ($urandom_range(1) == 1) send_byte(CH_CR, 1'b0);
      send_byte(CH_LF, 1'b0);
      if (len != 0) begin
         repeat (len) send_byte(8'($urandom), 1'b0);
         repeat ($urandom_range(2)) send_byte(CH_CR, 1'b0);
         if (bad_end) begin
            b = 8'($urandom);
            if (b == CH_LF || b == CH_CR) b = "?";
            send_byte(b, 1'b0);
         end else begin
            send_byte(CH_LF, 1'b0);
         end
      end
   endtask

   task automatic send_message();
      int          chunks;
      int unsigned len;
      bit          broke;
      chunks = int'($urandom_range(3));
      broke  = 1'b0;
      for (int k = 0; k < chunks && !broke; k++) begin
         len   = ($urandom_range(9) == 0) ? $urandom_range(60, 17) : $urandom_range(16, 1);
         broke = ($urandom_range(11) == 0);
         send_chunk(len, k == 0, broke);
      end
      if (broke) begin
         repeat ($urandom_range(4, 1)) send_byte(8'($urandom), 1'b0);
      end else begin
         send_chunk(0, chunks == 0, 1'b0);
         repeat ($urandom_range(3)) send_byte(8'($urandom), 1'b0);
      end
   endtask

   // size field at or just past the digit limit
   task automatic send_long_size();
      logic [63:0] v;
      int          nd;
      case ($urandom_range(2))
         0: v = '1;
         1: v = {$urandom, $urandom};
         default: v = 64'($urandom_range(8, 1));
      endcase
      nd = int'($urandom_range(17, 16));
      send_size(v, nd, 1'b1);
      send_byte(CH_LF, 1'b0);
      if (nd == 16 && v <= 8) begin
         repeat (int'(v)) send_byte(8'($urandom), 1'b0);
         send_byte(CH_LF, 1'b0);
      end else begin
         repeat ($urandom_range(3)) send_byte(8'($urandom), 1'b0);
      end
   endtask

   task automatic run_traffic(input int target);
      int pick;
      while (sent_count < target) begin
         pick = int'($urandom_range(99));
         if (pick < 70) begin
            send_message();
         end else if (pick < 82) begin
            send_long_size();
         end else begin
            repeat ($urandom_range(6, 1)) send_byte(8'($urandom), $urandom_range(7) == 0);
         end
      end
   endtask

   task automatic test_directed();
      // chunk with extension and extra crs
      send_byte("1", 1'b1);
      send_byte(";", 1'b0);
      send_byte("z", 1'b0);
      send_byte(CH_LF, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(CH_CR, 1'b0);
      send_byte(CH_CR, 1'b0);
      send_byte(CH_LF, 1'b0);
      // size ended by lf
      send_byte("2", 1'b0);
      send_byte(CH_LF, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'h80, 1'b0);
      send_byte(CH_LF, 1'b0);
      // final chunk and trailer
      send_byte("0", 1'b0);
      send_byte(CH_LF, 1'b0);
      send_byte(8'h7F, 1'b0);
      send_byte(CH_LF, 1'b0);
      // empty size, then swallowed byte
      send_byte(CH_LF, 1'b1);
      send_byte("A", 1'b0);
      // bad line end
      send_byte("1", 1'b1);
      send_byte(CH_LF, 1'b0);
      send_byte("x", 1'b0);
      send_byte("Q", 1'b0);
      send_byte("g", 1'b1);
   endtask

   task automatic test_random_stream();
      full_rate = 1'b0;
      run_traffic(300);
   endtask

   task automatic test_full_rate();
      full_rate = 1'b1;
      run_traffic(420);
   endtask

   always @(posedge clock) begin
      sink_ready <= (reset || full_rate) ? 1'b1 : ($urandom_range(99) >= 29);
   end

   always @(posedge clock) begin : check_results
      rsp_payload_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (expected_events.size() == 0) begin
            $error("unexpected transaction: event_res %0d", rsp_chan.payload.event_res);
            err_count++;
         end else begin
            want = expected_events.pop_front();
            if (rsp_chan.payload.event_res !== want.event_res) begin
               $error("event_res: expected %0d, actual %0d",
                      want.event_res, rsp_chan.payload.event_res);
               err_count++;
            end
            if (rsp_chan.payload.payload_byte !== want.payload_byte) begin
               $error("payload_byte: expected %0h, actual %0h",
                      want.payload_byte, rsp_chan.payload.payload_byte);
               err_count++;
            end
            if (rsp_chan.payload.chunk_length !== want.chunk_length) begin
               $error("chunk_length: expected %0h, actual %0h",
                      want.chunk_length, rsp_chan.payload.chunk_length);
               err_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      req_chan.valid   = 1'b0;
      req_chan.payload = '0;
      restart_parse();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_random_stream();
      test_full_rate();
      req_chan.valid <= 1'b0;
      while (expected_events.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (err_count == 0 && expected_events.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
